@@ design/periodic_task_timer_dispatcher_unit_macros.svh @@
// Assertion macros for the periodic task timer dispatcher.
`ifndef PERIODIC_TASK_TIMER_DISPATCHER_UNIT_MACROS_SVH
`define PERIODIC_TASK_TIMER_DISPATCHER_UNIT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every rising edge outside reset.
`define PTDU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptdu assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define PTDU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptdu assertion failed");

`else

`define PTDU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define PTDU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ design/ptdu_pkg.sv @@
// Shared types and constants of the periodic task timer dispatcher.
package ptdu_pkg;

    localparam int TASK_SLOTS = 8;
    localparam int TIMER_BITS = 16;
    localparam int SLOT_BITS  = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_DISPATCH = 2'd1,
        CMD_LOAD     = 2'd2,
        CMD_UNUSED   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  slot_index;
        logic [15:0] interval_ticks;
        logic        suspend_flag;
    } req_t;

    typedef struct packed {
        logic [3:0] task_id;
        logic       task_valid;
        logic       last;
    } rsp_t;

    // Result of one slot update in the shared timer unit.
    typedef struct packed {
        logic [TIMER_BITS-1:0] count_next;
        logic                  fire;
    } tmr_upd_t;

endpackage

@@ design/ptdu_timer_unit.sv @@
// Shared countdown unit: updates one task slot per tick step.
module ptdu_timer_unit
    import ptdu_pkg::*;
(
    input  logic [TIMER_BITS-1:0] countdown,
    input  logic [TIMER_BITS-1:0] interval,
    input  logic                  suspended,
    output tmr_upd_t              upd
);

    logic [TIMER_BITS-1:0] dec;

    assign dec = countdown - TIMER_BITS'(1);

    always_comb
    begin
        upd.count_next = countdown;
        upd.fire       = 1'b0;
        // Count down only running slots with time left; reload on expiry.
        if (!suspended && (countdown != '0))
        begin
            if (dec == '0)
            begin
                upd.count_next = interval;
                upd.fire       = 1'b1;
            end
            else
            begin
                upd.count_next = dec;
            end
        end
    end

endmodule

@@ design/periodic_task_timer_dispatcher_unit.sv @@
// Top level of the periodic task timer dispatcher: slot table, sequencer, output register.
//
// The block keeps TASK_SLOTS task slots, each with a reload interval, a countdown,
// a suspend flag and a ready flag. A load request writes one slot in the cycle it
// is accepted (a slot index beyond the table and the unused command are dropped)
// and produces no result. A tick request walks the slots one per cycle through a
// single shared decrement-and-compare unit; a slot whose countdown expires
// reloads and turns ready. A dispatch request walks the slots one per cycle in
// ascending order, holding on a ready slot while the output register cannot take
// a result, and sends one result for each ready, running slot, clearing its ready
// flag; it ends early once the final ready slot has been sent (that result
// carries last). If nothing is ready, a dispatch sends one result with
// task_valid low and last high. Suspended slots keep their ready flags until a
// later load, which clears them. The request side is stalled whenever the
// sequencer is busy with a walk or an empty result; results leave through a
// single output register, so the last result may still wait for the receiver
// while the next request is already taken.

`include "periodic_task_timer_dispatcher_unit_macros.svh"

module periodic_task_timer_dispatcher_unit
    import ptdu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_DISP,
        ST_NONE
    } state_t;

    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(TASK_SLOTS - 1);

    // Slot table
    logic [TIMER_BITS-1:0] interval_reg [TASK_SLOTS];
    logic [TIMER_BITS-1:0] count_reg    [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] ready_reg;
    logic [TASK_SLOTS-1:0] susp_reg;

    // Sequencer and output register
    state_t                state_reg, state_next;
    logic [SLOT_BITS-1:0]  idx_reg, idx_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_reg, rsp_next;

    logic                  req_accept;
    logic                  out_free;
    logic                  load_we;
    logic                  tick_we;
    logic                  clear_we;
    logic [SLOT_BITS-1:0]  load_idx;
    logic [TASK_SLOTS-1:0] run_mask;
    logic [TASK_SLOTS-1:0] above_mask;
    logic                  is_last;
    tmr_upd_t              upd;

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    assign load_idx = req.slot_index[SLOT_BITS-1:0];
    assign load_we  = req_accept && (req.command == CMD_LOAD)
                   && ({1'b0, req.slot_index} < 5'(TASK_SLOTS));

    // Slots that would dispatch now, and whether any lie above the walk position.
    assign run_mask   = ready_reg & ~susp_reg;
    assign above_mask = run_mask >> idx_reg;
    assign is_last    = ((above_mask >> 1) == '0);

    // One shared countdown unit serves the slot under the walk pointer.
    ptdu_timer_unit u_timer (
        .countdown (count_reg[idx_reg]),
        .interval  (interval_reg[idx_reg]),
        .suspended (susp_reg[idx_reg]),
        .upd       (upd)
    );

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        tick_we        = 1'b0;
        clear_we       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    idx_next = '0;
                    if (req.command == CMD_TICK)
                    begin
                        state_next = ST_TICK;
                    end
                    else if (req.command == CMD_DISPATCH)
                    begin
                        state_next = (run_mask == '0) ? ST_NONE : ST_DISP;
                    end
                end
            end

            ST_TICK:
            begin
                // Write back the updated countdown, then advance.
                tick_we = 1'b1;
                if (idx_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_BITS'(1);
                end
            end

            ST_DISP:
            begin
                if (run_mask[idx_reg])
                begin
                    // Hold the walk until the output register frees up.
                    if (out_free)
                    begin
                        clear_we            = 1'b1;
                        rsp_valid_next      = 1'b1;
                        rsp_next.task_id    = 4'(idx_reg);
                        rsp_next.task_valid = 1'b1;
                        rsp_next.last       = is_last;
                        if (is_last || (idx_reg == LAST_SLOT))
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg + SLOT_BITS'(1);
                        end
                    end
                end
                else if (idx_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_BITS'(1);
                end
            end

            ST_NONE:
            begin
                // Nothing ready: send one empty, final result.
                if (out_free)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.task_id    = '0;
                    rsp_next.task_valid = 1'b0;
                    rsp_next.last       = 1'b1;
                    state_next          = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    // Slot table updates: load, tick write-back and dispatch clear never overlap.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TASK_SLOTS; i++)
            begin
                interval_reg[i] <= '0;
                count_reg[i]    <= '0;
            end
            ready_reg <= '0;
            susp_reg  <= '0;
        end
        else
        begin
            if (load_we)
            begin
                interval_reg[load_idx] <= TIMER_BITS'(req.interval_ticks);
                count_reg[load_idx]    <= TIMER_BITS'(req.interval_ticks);
                susp_reg[load_idx]     <= req.suspend_flag;
                ready_reg[load_idx]    <= 1'b0;
            end
            if (tick_we)
            begin
                count_reg[idx_reg] <= upd.count_next;
                if (upd.fire)
                begin
                    ready_reg[idx_reg] <= 1'b1;
                end
            end
            if (clear_we)
            begin
                ready_reg[idx_reg] <= 1'b0;
            end
        end
    end

    // An empty result always closes its dispatch.
    `PTDU_ASSERT_IMPLIES(a_empty_is_last, clk, rst_n,
        rsp_valid_reg && !rsp_reg.task_valid, rsp_reg.last)

    // A non-final result means the dispatch walk is still running.
    `PTDU_ASSERT_IMPLIES(a_open_run_busy, clk, rst_n,
        rsp_valid_reg && !rsp_reg.last, state_reg == ST_DISP)

    // Ready flags only turn on during a tick walk.
    `PTDU_ASSERT_NEXT(a_ready_from_tick, clk, rst_n,
        state_reg != ST_TICK, (ready_reg & ~$past(ready_reg)) == '0)

    // A dispatched slot leaves the ready set.
    `PTDU_ASSERT_NEXT(a_dispatch_clears, clk, rst_n,
        clear_we, ready_reg[$past(idx_reg)] == 1'b0)

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the periodic task timer dispatcher unit.
module tb;
    import ptdu_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 11;
    localparam int RANDOM_REQUESTS = 350;
    // Receiver hold-off: start point (in counted requests) and length in cycles.
    localparam int HOLD_START      = 100;
    localparam int HOLD_CYCLES     = 300;
    // Calm stretch: no idling on either side for these counted requests.
    localparam int CALM_FIRST      = 200;
    localparam int CALM_LAST       = 280;
    localparam int IDLE_PERCENT    = 36;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 4 * TASK_SLOTS;
    localparam int MAX_REPORTS     = 10;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    // Flags from the request driver to the result-side process.
    logic hold_off_go;
    logic calm_stretch;
    int   cycle_count;

    periodic_task_timer_dispatcher_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Mirror of the slot table. Each accepted request updates the mirror; a dispatch
    // request appends the task ids it must produce to due_tasks, oldest first.
    class task_table_predictor;
        logic [TIMER_BITS-1:0] reload_q [TASK_SLOTS];
        logic [TIMER_BITS-1:0] count_q  [TASK_SLOTS];
        bit                    ready_q  [TASK_SLOTS];
        bit                    paused_q [TASK_SLOTS];
        rsp_t                  due_tasks[$];
        int                    mismatches;

        function new();
            for (int s = 0; s < TASK_SLOTS; s++)
            begin
                reload_q[s] = '0;
                count_q[s]  = '0;
                ready_q[s]  = 1'b0;
                paused_q[s] = 1'b0;
            end
            mismatches = 0;
        endfunction

        function void note_request(req_t r);
            rsp_t                 entry;
            int                   found;
            logic [SLOT_BITS-1:0] slot;
            found = 0;
            case (cmd_t'(r.command))
                CMD_TICK:
                begin
                    // Count down every running slot; reload and flag ready on expiry.
                    for (int s = 0; s < TASK_SLOTS; s++)
                    begin
                        if (!paused_q[s] && count_q[s] != '0)
                        begin
                            count_q[s] = count_q[s] - 1'b1;
                            if (count_q[s] == '0)
                            begin
                                count_q[s] = reload_q[s];
                                ready_q[s] = 1'b1;
                            end
                        end
                    end
                end
                CMD_DISPATCH:
                begin
                    // Emit ready, running slots in ascending order; suspended ones wait.
                    for (int s = 0; s < TASK_SLOTS; s++)
                    begin
                        if (ready_q[s] && !paused_q[s])
                        begin
                            ready_q[s]       = 1'b0;
                            entry.task_id    = s[3:0];
                            entry.task_valid = 1'b1;
                            entry.last       = 1'b0;
                            due_tasks.push_back(entry);
                            found++;
                        end
                    end
                    if (found == 0)
                    begin
                        entry.task_id    = '0;
                        entry.task_valid = 1'b0;
                        entry.last       = 1'b1;
                        due_tasks.push_back(entry);
                    end
                    else
                    begin
                        due_tasks[due_tasks.size() - 1].last = 1'b1;
                    end
                end
                CMD_LOAD:
                begin
                    // Drop loads that point past the table.
                    if (r.slot_index < TASK_SLOTS)
                    begin
                        slot           = r.slot_index[SLOT_BITS-1:0];
                        reload_q[slot] = r.interval_ticks[TIMER_BITS-1:0];
                        count_q[slot]  = r.interval_ticks[TIMER_BITS-1:0];
                        paused_q[slot] = r.suspend_flag;
                        ready_q[slot]  = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (due_tasks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: task_id=%0d task_valid=%0b last=%0b",
                             got.task_id, got.task_valid, got.last);
                return;
            end
            want = due_tasks.pop_front();
            if (got.task_id !== want.task_id || got.task_valid !== want.task_valid ||
                got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"result mismatch: expected task_id=%0d task_valid=%0b ",
                              "last=%0b, got task_id=%0d task_valid=%0b last=%0b"},
                             want.task_id, want.task_valid, want.last,
                             got.task_id, got.task_valid, got.last);
            end
        endfunction
    endclass

    task_table_predictor predictor = new();

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Timeout guard: end the run as failed if the limit is reached.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Check every accepted result against the oldest expectation. Values are
    // sampled at the edge, before any nonblocking update of that edge lands.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            predictor.check_result(rsp);
    end

    // Result side: random stalls, a calm stretch with none, and one long hold-off
    // counted here so that the block backs up and stalls new requests.
    initial
    begin
        int held;
        held = 0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_go && held < HOLD_CYCLES)
            begin
                rsp_stall <= 1'b1;
                held++;
            end
            else if (calm_stretch)
                rsp_stall <= 1'b0;
            else
                rsp_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    function automatic req_t make_request(cmd_t c, int slot, int ticks, bit susp);
        req_t r;
        r.command        = c;
        r.slot_index     = slot[3:0];
        r.interval_ticks = ticks[15:0];
        r.suspend_flag   = susp;
        return r;
    endfunction

    // Mostly short intervals so slots really fire; some zero, some full range,
    // a few loads past the table and some unused commands as noise.
    function automatic req_t random_request();
        req_t r;
        int   pick;
        int   span;
        r.slot_index     = 4'($urandom_range(0, 15));
        r.interval_ticks = 16'($urandom_range(0, 65535));
        r.suspend_flag   = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 45)
            r.command = CMD_TICK;
        else if (pick < 67)
            r.command = CMD_DISPATCH;
        else if (pick < 95)
        begin
            r.command = CMD_LOAD;
            if ($urandom_range(0, 99) < 88)
                r.slot_index = 4'($urandom_range(0, TASK_SLOTS - 1));
            span = $urandom_range(0, 99);
            if (span < 70)
                r.interval_ticks = 16'($urandom_range(1, 6));
            else if (span < 80)
                r.interval_ticks = '0;
            r.suspend_flag = ($urandom_range(0, 99) < 20);
        end
        else
            r.command = CMD_UNUSED;
        return r;
    endfunction

    // Offer one request, idling first at random, and hold it until accepted.
    task automatic send_request(req_t r, bit may_idle);
        while (may_idle && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predictor.note_request(r);
    endtask

    initial
    begin
        req_t r;
        int   counted;
        bit   calm;
        counted = 0;
        rst_n        <= 1'b0;
        req_valid    <= 1'b0;
        req          <= '0;
        hold_off_go  <= 1'b0;
        calm_stretch <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Dispatch with nothing ready first.
        send_request(make_request(CMD_DISPATCH, 0, 0, 1'b0), 1'b1);
        send_request(make_request(CMD_LOAD, 0, 1, 1'b0), 1'b1);
        send_request(make_request(CMD_LOAD, 7, 2, 1'b0), 1'b1);
        // Zero interval never fires; a suspended slot is skipped.
        send_request(make_request(CMD_LOAD, 3, 0, 1'b0), 1'b1);
        send_request(make_request(CMD_LOAD, 5, 1, 1'b1), 1'b1);
        send_request(make_request(CMD_LOAD, 2, 65535, 1'b0), 1'b1);
        // Loads past the table and the unused command must leave no trace.
        send_request(make_request(CMD_LOAD, 15, 65535, 1'b1), 1'b1);
        send_request(make_request(CMD_LOAD, TASK_SLOTS, 1, 1'b0), 1'b1);
        send_request(make_request(CMD_UNUSED, 15, 65535, 1'b1), 1'b1);
        send_request(make_request(CMD_TICK, 0, 0, 1'b0), 1'b1);
        send_request(make_request(CMD_TICK, 0, 0, 1'b0), 1'b1);
        send_request(make_request(CMD_DISPATCH, 0, 0, 1'b0), 1'b1);
        // Every slot ready at once: the longest dispatch run.
        for (int s = 0; s < TASK_SLOTS; s++)
            send_request(make_request(CMD_LOAD, s, 1, 1'b0), 1'b1);
        send_request(make_request(CMD_TICK, 0, 0, 1'b0), 1'b1);
        send_request(make_request(CMD_DISPATCH, 0, 0, 1'b0), 1'b1);
        send_request(make_request(CMD_DISPATCH, 0, 0, 1'b0), 1'b1);

        // Random part. Every offered request counts, dropped ones included.
        while (counted < RANDOM_REQUESTS)
        begin
            calm = (counted >= CALM_FIRST && counted < CALM_LAST);
            if (counted == HOLD_START)
                hold_off_go <= 1'b1;
            calm_stretch <= calm;
            r = random_request();
            send_request(r, !calm);
            counted++;
        end
        req_valid    <= 1'b0;
        calm_stretch <= 1'b0;

        // Drain: wait for every expected result, then a few more walks' worth.
        while (predictor.due_tasks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (predictor.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+design
design/ptdu_pkg.sv
design/ptdu_timer_unit.sv
design/periodic_task_timer_dispatcher_unit.sv
tb/tb.sv
